// ----- rtl/ffb_pkg.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// ffb_pkg
// Shared constants and state type for the fragmenting frame builder.
// -----------------------------------------------------------------------------
package ffb_pkg;

   localparam int unsigned FRAGMENT_BYTES_DEF = 23;

   localparam logic [7:0] HEADER_BYTE       = 8'hFF;
   localparam logic [7:0] FOOTER_BYTE       = 8'h7E;
   localparam logic [7:0] PAD_BYTE          = 8'h00;
   localparam logic [7:0] OWN_ADDRESS_RESET = 8'h44;

   typedef enum logic [3:0] {
      ST_COLLECT,
      ST_HEADER,
      ST_CTRL1,
      ST_CTRL2,
      ST_DEST,
      ST_OWN,
      ST_LEN,
      ST_DATA,
      ST_PARITY,
      ST_PAD,
      ST_FOOTER
   } ffb_state_type;

endpackage : ffb_pkg
`default_nettype wire

// ----- rtl/fragmenting_frame_builder_unit.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// fragmenting_frame_builder_unit
// Link-layer framer: cuts packets into fragments and emits one frame each.
// -----------------------------------------------------------------------------
// Usage:
//   req_* carries packet bytes; req_last_of_packet marks the final byte and
//   req_dest_address is sampled on the first byte of a packet. Each item is
//   written into the fragment store as it is accepted.
//   When a fragment fills (FRAGMENT_BYTES bytes) or the packet ends, the block
//   stalls the input and sends a frame on rsp_* of fill + 9 bytes, one byte
//   per cycle: header, two control bytes, destination, own address, length,
//   payload, parity, pad, footer (rsp_end_of_frame high on the footer).
//   Payload bytes stream from the store through its registered read port.
//   Throughput: one input byte per cycle while filling; the input stalls
//   while the single frame sequencer sends a frame. The first frame byte
//   is valid once the sequencer has reached ST_HEADER and loaded the header
//   into the output register. rsp_stall holds the output register and the
//   sequencer; the next item is taken while the footer still waits in the
//   output register. csr_wr_en writes own_address (reset value 0x44); the
//   user must write it only while the block is idle, which is not enforced.
//   Synchronous reset clears counters, sequence and the output valid.
// -----------------------------------------------------------------------------
module fragmenting_frame_builder_unit #(
   parameter int unsigned FRAGMENT_BYTES = ffb_pkg::FRAGMENT_BYTES_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_payload_byte,
   input  wire logic       req_last_of_packet,
   input  wire logic [7:0] req_dest_address,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic      [7:0] rsp_frame_byte,
   output logic            rsp_end_of_frame,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data
);

   import ffb_pkg::*;

   localparam int unsigned AW = (FRAGMENT_BYTES > 1) ? $clog2(FRAGMENT_BYTES) : 1;
   localparam int unsigned CW = $clog2(FRAGMENT_BYTES + 1);

   logic [7:0]    own_address_ff;
   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [7:0]    mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   logic [7:0]    mem_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= OWN_ADDRESS_RESET;
      end else if (csr_wr_en) begin
         own_address_ff <= csr_wr_data;
      end
   end

   ffb_ctrl #(
      .FRAGMENT_BYTES (FRAGMENT_BYTES),
      .AW             (AW),
      .CW             (CW)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_payload_byte   (req_payload_byte),
      .req_last_of_packet (req_last_of_packet),
      .req_dest_address   (req_dest_address),
      .own_address        (own_address_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_byte     (rsp_frame_byte),
      .rsp_end_of_frame   (rsp_end_of_frame),
      .mem_wr_en          (mem_wr_en),
      .mem_wr_addr        (mem_wr_addr),
      .mem_wr_data        (mem_wr_data),
      .mem_rd_en          (mem_rd_en),
      .mem_rd_addr        (mem_rd_addr),
      .mem_rd_data        (mem_rd_data)
   );

   ffb_store #(
      .DEPTH (FRAGMENT_BYTES),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule : fragmenting_frame_builder_unit
`default_nettype wire

// ----- rtl/ffb_store.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// ffb_store
// Fragment byte store: one write port, one read port with registered data.
// -----------------------------------------------------------------------------
module ffb_store #(
   parameter int unsigned DEPTH = 23,
   parameter int unsigned AW    = 5
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : ffb_store
`default_nettype wire

// ----- rtl/ffb_ctrl.sv -----
`default_nettype none
// -----------------------------------------------------------------------------
// ffb_ctrl
// Fragment fill control and frame sequencer with output register.
// -----------------------------------------------------------------------------
module ffb_ctrl #(
   parameter int unsigned FRAGMENT_BYTES = 23,
   parameter int unsigned AW             = 5,
   parameter int unsigned CW             = 5
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [7:0]    req_payload_byte,
   input  wire logic          req_last_of_packet,
   input  wire logic [7:0]    req_dest_address,
   input  wire logic [7:0]    own_address,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic      [7:0]    rsp_frame_byte,
   output logic               rsp_end_of_frame,
   output logic               mem_wr_en,
   output logic      [AW-1:0] mem_wr_addr,
   output logic      [7:0]    mem_wr_data,
   output logic               mem_rd_en,
   output logic      [AW-1:0] mem_rd_addr,
   input  wire logic [7:0]    mem_rd_data
);

   import ffb_pkg::*;

   localparam logic [CW-1:0] LAST_FILL = CW'(FRAGMENT_BYTES - 1);

   ffb_state_type state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [3:0]    frag_ff, frag_in;
   logic [3:0]    seq_ff, seq_in;
   logic [7:0]    dest_ff, dest_in;
   logic          par_ff, par_in;
   logic          in_packet_ff, in_packet_in;
   logic          more_ff, more_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_eof_ff, rsp_eof_in;

   logic       accept;
   logic       load;
   logic [7:0] ctrl1;
   logic [7:0] ctrl2;
   logic       frame_parity;

   assign ctrl1 = {frag_ff, seq_ff};
   assign ctrl2 = {more_ff, 4'b0000, (dest_ff != 8'h00), 2'b00};
   assign frame_parity = (^HEADER_BYTE) ^ (^ctrl1) ^ (^ctrl2) ^ (^dest_ff)
                       ^ (^own_address) ^ (^8'(fill_ff)) ^ par_ff;

   assign req_stall = (state_ff != ST_COLLECT);
   assign accept    = req_valid && !req_stall;
   assign load      = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         fill_ff      <= '0;
         idx_ff       <= '0;
         frag_ff      <= '0;
         seq_ff       <= '0;
         dest_ff      <= '0;
         par_ff       <= 1'b0;
         in_packet_ff <= 1'b0;
         more_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         frag_ff      <= frag_in;
         seq_ff       <= seq_in;
         dest_ff      <= dest_in;
         par_ff       <= par_in;
         in_packet_ff <= in_packet_in;
         more_ff      <= more_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_eof_ff  <= rsp_eof_in;
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      frag_in      = frag_ff;
      seq_in       = seq_ff;
      dest_in      = dest_ff;
      par_in       = par_ff;
      in_packet_in = in_packet_ff;
      more_in      = more_ff;
      rsp_valid_in = load ? 1'b0 : rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_eof_in   = rsp_eof_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = fill_ff[AW-1:0];
      mem_wr_data  = req_payload_byte;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = idx_ff[AW-1:0];

      unique case (state_ff)
         ST_COLLECT: begin
            if (accept) begin
               mem_wr_en    = 1'b1;
               if (!in_packet_ff) begin
                  dest_in = req_dest_address;
               end
               in_packet_in = 1'b1;
               fill_in      = fill_ff + 1'b1;
               par_in       = par_ff ^ (^req_payload_byte);
               if (req_last_of_packet) begin
                  more_in  = 1'b0;
                  state_in = ST_HEADER;
               end else if (fill_ff == LAST_FILL) begin
                  more_in  = 1'b1;
                  state_in = ST_HEADER;
               end
            end
         end
         ST_HEADER: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = HEADER_BYTE;
               rsp_eof_in   = 1'b0;
               state_in     = ST_CTRL1;
            end
         end
         ST_CTRL1: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = ctrl1;
               rsp_eof_in   = 1'b0;
               state_in     = ST_CTRL2;
            end
         end
         ST_CTRL2: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = ctrl2;
               rsp_eof_in   = 1'b0;
               state_in     = ST_DEST;
            end
         end
         ST_DEST: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = dest_ff;
               rsp_eof_in   = 1'b0;
               state_in     = ST_OWN;
            end
         end
         ST_OWN: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = own_address;
               rsp_eof_in   = 1'b0;
               state_in     = ST_LEN;
            end
         end
         ST_LEN: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = 8'(fill_ff);
               rsp_eof_in   = 1'b0;
               mem_rd_en    = 1'b1;
               mem_rd_addr  = '0;
               idx_in       = CW'(1);
               state_in     = ST_DATA;
            end
         end
         ST_DATA: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = mem_rd_data;
               rsp_eof_in   = 1'b0;
               if (idx_ff == fill_ff) begin
                  state_in = ST_PARITY;
               end else begin
                  mem_rd_en = 1'b1;
                  idx_in    = idx_ff + 1'b1;
               end
            end
         end
         ST_PARITY: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = {7'b0000000, frame_parity};
               rsp_eof_in   = 1'b0;
               state_in     = ST_PAD;
            end
         end
         ST_PAD: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = PAD_BYTE;
               rsp_eof_in   = 1'b0;
               state_in     = ST_FOOTER;
            end
         end
         ST_FOOTER: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = FOOTER_BYTE;
               rsp_eof_in   = 1'b1;
               fill_in      = '0;
               par_in       = 1'b0;
               if (more_ff) begin
                  frag_in = frag_ff + 1'b1;
               end else begin
                  frag_in      = '0;
                  seq_in       = seq_ff + 1'b1;
                  in_packet_in = 1'b0;
               end
               state_in = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_byte   = rsp_byte_ff;
   assign rsp_end_of_frame = rsp_eof_ff;

endmodule : ffb_ctrl
`default_nettype wire
